@@ rtl/chip8_instruction_execute_top_defines.svh @@
// Assertion macros for the CHIP-8 execute block
`ifndef CHIP8_INSTRUCTION_EXECUTE_TOP_DEFINES_SVH
`define CHIP8_INSTRUCTION_EXECUTE_TOP_DEFINES_SVH
// assert an implication on every clock edge outside reset
`define C8_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// assert an implication that must hold in the cycle after the antecedent
`define C8_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ rtl/c8ex_pkg.sv @@
// Shared types and constants for the CHIP-8 execute block
package c8ex_pkg;
	localparam logic [1:0] CMD_EXEC  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;
	localparam logic [1:0] CMD_START = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_OVER  = 2'd1;
	localparam logic [1:0] ST_UNDER = 2'd2;
	localparam logic [1:0] ST_DISP  = 2'd3;

	localparam logic [15:0] OP_CLS = 16'h00E0;
	localparam logic [15:0] OP_RET = 16'h00EE;
	localparam logic [7:0] FX_DELAY_GET = 8'h07;
	localparam logic [7:0] FX_KEY       = 8'h0A;
	localparam logic [7:0] FX_DELAY_SET = 8'h15;
	localparam logic [7:0] FX_SOUND_SET = 8'h18;
	localparam logic [7:0] FX_ADD_I     = 8'h1E;
	localparam logic [7:0] FX_GLYPH     = 8'h29;
	localparam logic [7:0] FX_BCD       = 8'h33;
	localparam logic [7:0] FX_STORE     = 8'h55;
	localparam logic [7:0] FX_LOAD      = 8'h65;
	localparam logic [7:0] EX_KEY_DOWN  = 8'h9E;
	localparam logic [7:0] EX_KEY_UP    = 8'hA1;
	localparam int FONT_BYTES = 80;
	localparam int GLYPH_HEIGHT = 5;

	typedef enum logic [3:0] {
		S_IDLE, S_CLEAR, S_RDX, S_RDY, S_EXEC, S_RET, S_BCD, S_STORE_RD, S_STORE_WR,
		S_LOAD_RD, S_LOAD_WR, S_MEMRD, S_DONE
	} c8_state_t;

	typedef struct packed {
		logic [11:0] pc;
		logic [15:0] idx;
		logic [7:0]  vf;
		logic [7:0]  dly;
		logic [7:0]  snd;
		logic [7:0]  rd;
		logic [1:0]  st;
	} c8_result_t;

	function automatic logic [7:0] font_byte(input logic [6:0] a);
		logic [7:0] f [0:79];
		f = '{8'hf0,8'h90,8'h90,8'h90,8'hf0,8'h20,8'h60,8'h20,8'h20,8'h70,
			8'hf0,8'h10,8'hf0,8'h80,8'hf0,8'hf0,8'h10,8'hf0,8'h10,8'hf0,
			8'h90,8'h90,8'hf0,8'h10,8'h10,8'hf0,8'h80,8'hf0,8'h10,8'hf0,
			8'hf0,8'h80,8'hf0,8'h90,8'hf0,8'hf0,8'h10,8'h20,8'h40,8'h40,
			8'hf0,8'h90,8'hf0,8'h90,8'hf0,8'hf0,8'h90,8'hf0,8'h10,8'hf0,
			8'hf0,8'h90,8'hf0,8'h90,8'h90,8'he0,8'h90,8'he0,8'h90,8'he0,
			8'hf0,8'h80,8'h80,8'h80,8'hf0,8'he0,8'h90,8'h90,8'h90,8'he0,
			8'hf0,8'h80,8'hf0,8'h80,8'hf0,8'hf0,8'h80,8'hf0,8'h80,8'h80};
		if (a < 7'(FONT_BYTES))
			return f[a];
		return 8'h00;
	endfunction
endpackage

@@ rtl/c8ex_ram.sv @@
// Generic single-port RAM with registered read
module c8ex_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

@@ rtl/chip8_instruction_execute_top.sv @@
// Channel   | signals                                      | direction
// in        | in_valid, in_stall, command..random_value     | receive
// out       | out_valid, out_stall, program_counter..status | send
// Each transaction keeps in_stall high from accept until the block returns to S_IDLE;
// Fx55 and Fx65 move one register at a time, set by the single port of each memory.
// After reset the block writes the font and zeros into main memory (and zeros into
// the register file) with in_stall high.
// A result waits in the output register while the next transaction runs; that one
// holds in its last state until out_stall releases the waiting result.
module chip8_instruction_execute_top #(
	parameter int MEMORY_BYTES = 4096,
	parameter int STACK_DEPTH  = 16,
	parameter int LOAD_ADDRESS = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [15:0] opcode,
	input  logic [11:0] address,
	input  logic [7:0]  data_byte,
	input  logic [15:0] keys_down,
	input  logic [3:0]  wait_key,
	input  logic [7:0]  random_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] program_counter,
	output logic [15:0] index_value,
	output logic [7:0]  flag_value,
	output logic [7:0]  delay_value,
	output logic [7:0]  sound_value,
	output logic [7:0]  read_data,
	output logic [1:0]  status
);
	import c8ex_pkg::*;
	localparam int MAW = $clog2(MEMORY_BYTES);
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int LVW = $clog2(STACK_DEPTH + 1);

	c8_state_t state_q, state_d;
	logic [1:0]  cmd_q;
	logic [15:0] op_q;
	logic [11:0] addr_q;
	logic [7:0]  data_q, rnd_q;
	logic [15:0] keys_q;
	logic [3:0]  key_q;
	logic [7:0]  vx_q, vy_q;
	logic [7:0]  alu_q, alu_d;
	logic [3:0]  cnt_q, cnt_d;
	logic [1:0]  bcd_q, bcd_d;
	logic [MAW-1:0] clr_q, clr_d;
	logic [11:0] pc_q, pc_d;
	logic [15:0] idx_q, idx_d;
	logic [7:0]  vf_q, vf_d, dly_q, dly_d, snd_q, snd_d;
	logic [LVW-1:0] lvl_q, lvl_d;
	c8_result_t res_q, res_d;
	logic out_v_q, out_v_d;
	logic ret_done_q, call_done_q;

	// register file, main memory and call stack
	logic        rf_we;
	logic [3:0]  rf_a;
	logic [7:0]  rf_wd, rf_rd;
	logic        mm_we;
	logic [MAW-1:0] mm_a;
	logic [7:0]  mm_wd, mm_rd;
	logic        sk_we;
	logic [SAW-1:0] sk_a;
	logic [11:0] sk_rd;

	c8ex_ram #(.WIDTH(8), .DEPTH(16)) u_regs (
		.clk(clk), .we(rf_we), .addr(rf_a), .wdata(rf_wd), .rdata(rf_rd));
	c8ex_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_mem (
		.clk(clk), .we(mm_we), .addr(mm_a), .wdata(mm_wd), .rdata(mm_rd));
	c8ex_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(sk_we), .addr(sk_a), .wdata(pc_q), .rdata(sk_rd));

	logic [3:0] x, y;
	logic [7:0] kk;
	logic [8:0] sum9;
	logic       down;
	logic [7:0] hund, tens, ones;
	logic [15:0] ibase;

	assign x  = op_q[11:8];
	assign y  = op_q[7:4];
	assign kk = op_q[7:0];
	assign ibase = idx_q + 16'(cnt_q);
	assign down = keys_q[vx_q[3:0]];

	always_comb begin
		hund = (vx_q >= 8'd200) ? 8'd2 : (vx_q >= 8'd100) ? 8'd1 : 8'd0;
		ones = vx_q - 8'(hund * 8'd100);
		tens = 8'((16'(ones) * 16'd205) >> 11);
		ones = ones - 8'(tens * 8'd10);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			pc_q    <= '0;
			idx_q   <= '0;
			vf_q    <= '0;
			dly_q   <= '0;
			snd_q   <= '0;
			lvl_q   <= '0;
			out_v_q <= 1'b0;
			cnt_q   <= '0;
			bcd_q   <= '0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			pc_q    <= pc_d;
			idx_q   <= idx_d;
			vf_q    <= vf_d;
			dly_q   <= dly_d;
			snd_q   <= snd_d;
			lvl_q   <= lvl_d;
			out_v_q <= out_v_d;
			cnt_q   <= cnt_d;
			bcd_q   <= bcd_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		alu_q <= alu_d;
		if (state_q == S_IDLE && in_valid) begin
			cmd_q  <= command;
			op_q   <= opcode;
			addr_q <= address;
			data_q <= data_byte;
			keys_q <= keys_down;
			key_q  <= wait_key;
			rnd_q  <= random_value;
		end
		if (state_q == S_RDX)
			vx_q <= rf_rd;
		if (state_q == S_RDY)
			vy_q <= rf_rd;
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		logic [7:0] res8;
		logic [7:0] fl;
		logic       wr;
		state_d = state_q;
		clr_d = clr_q;
		pc_d = pc_q; idx_d = idx_q; vf_d = vf_q; dly_d = dly_q; snd_d = snd_q;
		lvl_d = lvl_q; cnt_d = cnt_q; bcd_d = bcd_q;
		res_d = res_q;
		alu_d = alu_q;
		out_v_d = out_v_q && out_stall;
		rf_we = 1'b0; rf_a = x; rf_wd = '0;
		mm_we = 1'b0; mm_a = MAW'(ibase); mm_wd = '0;
		sk_we = 1'b0; sk_a = SAW'(lvl_q);
		res8 = '0; fl = '0; wr = 1'b0;
		sum9 = 9'(vx_q) + 9'(vy_q);
		case (state_q)
			S_CLEAR: begin
				mm_we = 1'b1;
				mm_a  = clr_q;
				mm_wd = font_byte(7'(clr_q < MAW'(FONT_BYTES) ? clr_q : MAW'(FONT_BYTES)));
				rf_we = 1'b1;
				rf_a  = clr_q[3:0];
				clr_d = clr_q + 1'b1;
				if (clr_q == MAW'(MEMORY_BYTES - 1))
					state_d = S_IDLE;
			end
			S_IDLE: begin
				rf_a = opcode[11:8];
				if (in_valid) begin
					cnt_d = '0;
					bcd_d = '0;
					state_d = S_RDX;
				end
			end
			S_RDX: begin
				// Bnnn needs V0 instead of Vy
				rf_a = (op_q[15:12] == 4'hB) ? 4'h0 : y;
				state_d = S_RDY;
				if (cmd_q == CMD_READ) begin
					mm_a = MAW'(addr_q);
					state_d = S_MEMRD;
				end else if (cmd_q == CMD_WRITE) begin
					mm_we = 1'b1;
					mm_a = MAW'(addr_q);
					mm_wd = data_q;
					state_d = S_DONE;
				end else if (cmd_q == CMD_START) begin
					pc_d = 12'(LOAD_ADDRESS);
					state_d = S_DONE;
				end else if (op_q == OP_RET) begin
					if (lvl_q == '0)
						state_d = S_DONE;
					else begin
						lvl_d = lvl_q - 1'b1;
						sk_a = SAW'(lvl_q - 1'b1);
						state_d = S_RET;
					end
				end
			end
			S_MEMRD: begin
				mm_a = MAW'(addr_q);
				state_d = S_DONE;
			end
			S_RET: begin
				pc_d = sk_rd;
				state_d = S_DONE;
			end
			S_RDY: begin
				state_d = S_DONE;
				if (op_q != OP_CLS && op_q != OP_RET) begin
				case (op_q[15:12])
					4'h1: pc_d = op_q[11:0];
					4'h2: begin
						if (lvl_q < LVW'(STACK_DEPTH)) begin
							sk_we = 1'b1;
							lvl_d = lvl_q + 1'b1;
							pc_d = op_q[11:0];
						end
					end
					4'h3: if (vx_q == kk) pc_d = pc_q + 12'd2;
					4'h4: if (vx_q != kk) pc_d = pc_q + 12'd2;
					4'h5: if (vx_q == rf_rd) pc_d = pc_q + 12'd2;
					4'h9: if (vx_q != rf_rd) pc_d = pc_q + 12'd2;
					4'h6: begin wr = 1'b1; res8 = kk; end
					4'h7: begin wr = 1'b1; res8 = vx_q + kk; end
					4'hA: idx_d = {4'h0, op_q[11:0]};
					4'hB: pc_d = op_q[11:0] + 12'(rf_rd);
					4'hC: begin wr = 1'b1; res8 = rnd_q & kk; end
					4'hE: begin
						if (kk == EX_KEY_DOWN && down) pc_d = pc_q + 12'd2;
						if (kk == EX_KEY_UP && !down) pc_d = pc_q + 12'd2;
					end
					4'h8: state_d = S_EXEC;
					4'hF: begin
						case (kk)
							FX_DELAY_GET: begin wr = 1'b1; res8 = dly_q; end
							FX_KEY:       begin wr = 1'b1; res8 = {4'h0, key_q}; end
							FX_DELAY_SET: dly_d = vx_q;
							FX_SOUND_SET: snd_d = vx_q;
							FX_ADD_I:     idx_d = idx_q + 16'(vx_q);
							FX_GLYPH:     idx_d = 16'(vx_q) * 16'(GLYPH_HEIGHT);
							FX_BCD:       state_d = S_BCD;
							FX_STORE:     begin rf_a = '0; state_d = S_STORE_RD; end
							FX_LOAD:      begin mm_a = MAW'(idx_q); state_d = S_LOAD_RD; end
							default: ;
						endcase
					end
					default: ;
				endcase
				end
				if (wr) begin
					rf_we = 1'b1; rf_a = x; rf_wd = res8;
					if (x == 4'hF) vf_d = res8;
				end
			end
			S_EXEC: begin
				// 8xyn ALU, vy_q now holds Vy
				rf_a = x;
				state_d = S_DONE;
				sum9 = 9'(vx_q) + 9'(vy_q);
				case (op_q[3:0])
					4'h0: begin wr = 1'b1; res8 = vy_q; end
					4'h1: begin wr = 1'b1; res8 = vx_q | vy_q; end
					4'h2: begin wr = 1'b1; res8 = vx_q & vy_q; end
					4'h3: begin wr = 1'b1; res8 = vx_q ^ vy_q; end
					4'h4: begin wr = 1'b1; res8 = sum9[7:0]; fl = {7'd0, sum9[8]}; end
					4'h5: begin
						wr = 1'b1; fl = {7'd0, vx_q > vy_q};
						res8 = (x == 4'hF ? fl : vx_q) - (y == 4'hF ? fl : vy_q);
					end
					4'h6: begin wr = 1'b1; fl = {7'd0, vx_q[0]}; res8 = vx_q >> 1; end
					4'h7: begin
						wr = 1'b1; fl = {7'd0, vy_q > vx_q};
						res8 = (y == 4'hF ? fl : vy_q) - (x == 4'hF ? fl : vx_q);
					end
					4'hE: begin wr = 1'b1; fl = {7'd0, vx_q[7]}; res8 = vx_q << 1; end
					default: ;
				endcase
				if (wr) begin
					if (op_q[3:0] == 4'h0 || op_q[3:0] == 4'h1 || op_q[3:0] == 4'h2 ||
						op_q[3:0] == 4'h3) begin
						rf_we = 1'b1; rf_a = x; rf_wd = res8;
						if (x == 4'hF) vf_d = res8;
					end else begin
						// flag first; hold the result and write it next cycle
						rf_we = 1'b1; rf_a = 4'hF; rf_wd = fl; vf_d = fl;
						state_d = S_BCD;
						bcd_d = 2'd3;
						alu_d = res8;
					end
				end
			end
			S_BCD: begin
				if (bcd_q == 2'd3) begin
					// deferred ALU result write
					rf_we = 1'b1; rf_a = x; rf_wd = alu_q;
					if (x == 4'hF) vf_d = alu_q;
					state_d = S_DONE;
				end else begin
					mm_we = 1'b1;
					mm_a = MAW'(idx_q + 16'(bcd_q));
					mm_wd = (bcd_q == 2'd0) ? hund : (bcd_q == 2'd1) ? tens : ones;
					bcd_d = bcd_q + 1'b1;
					if (bcd_q == 2'd2) state_d = S_DONE;
				end
			end
			S_STORE_RD: begin
				rf_a = cnt_q;
				state_d = S_STORE_WR;
			end
			S_STORE_WR: begin
				mm_we = 1'b1; mm_wd = rf_rd;
				cnt_d = cnt_q + 1'b1;
				rf_a = cnt_q + 1'b1;
				state_d = (cnt_q == x) ? S_DONE : S_STORE_RD;
			end
			S_LOAD_RD: begin
				state_d = S_LOAD_WR;
			end
			S_LOAD_WR: begin
				rf_we = 1'b1; rf_a = cnt_q; rf_wd = mm_rd;
				if (cnt_q == 4'hF) vf_d = mm_rd;
				cnt_d = cnt_q + 1'b1;
				mm_a = MAW'(ibase + 16'd1);
				state_d = (cnt_q == x) ? S_DONE : S_LOAD_RD;
			end
			S_DONE: begin
				// keep the read address so mm_rd holds while waiting
				if (cmd_q == CMD_READ) mm_a = MAW'(addr_q);
				if (!(out_v_q && out_stall)) begin
					res_d.pc = pc_q; res_d.idx = idx_q; res_d.vf = vf_q;
					res_d.dly = dly_q; res_d.snd = snd_q;
					res_d.rd = (cmd_q == CMD_READ) ? mm_rd : 8'h00;
					res_d.st = ST_OK;
					if (cmd_q == CMD_EXEC) begin
						if (op_q == OP_CLS || op_q[15:12] == 4'hD) res_d.st = ST_DISP;
						else if (op_q == OP_RET && lvl_q == '0 && !ret_done_q)
							res_d.st = ST_UNDER;
						else if (op_q[15:12] == 4'h2 && !call_done_q) res_d.st = ST_OVER;
					end
					out_v_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// track whether a call or return actually took effect
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ret_done_q  <= 1'b0;
			call_done_q <= 1'b0;
		end else if (state_q == S_IDLE) begin
			ret_done_q  <= 1'b0;
			call_done_q <= 1'b0;
		end else begin
			if (state_q == S_RET) ret_done_q <= 1'b1;
			if (sk_we) call_done_q <= 1'b1;
		end
	end

	assign out_valid       = out_v_q;
	assign program_counter = res_q.pc;
	assign index_value     = res_q.idx;
	assign flag_value      = res_q.vf;
	assign delay_value     = res_q.dly;
	assign sound_value     = res_q.snd;
	assign read_data       = res_q.rd;
	assign status          = res_q.st;
endmodule

@@ rtl/c8ex_checker.sv @@
// Port-level assertions for the CHIP-8 execute block
`include "chip8_instruction_execute_top_defines.svh"
module c8ex_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [7:0]  read_data,
	input logic [11:0] program_counter
);
	// a presented result carries known values
	`C8_ASSERT_IMP(a_known_result, clk, arst_n, out_valid, !$isunknown({status, read_data, program_counter}), "unknown result")
	// one transaction at a time: stall right after an accept
	`C8_ASSERT_NEXT(a_busy, clk, arst_n, in_valid && !in_stall, in_stall, "accept on back-to-back cycles")
	// a stalled result holds
	`C8_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(read_data) && $stable(program_counter), "result changed under stall")
	// an accept while no result is presented cannot produce a result on the next edge
	`C8_ASSERT_NEXT(a_latency, clk, arst_n, in_valid && !in_stall && !out_valid, !out_valid, "result too early")
endmodule

bind chip8_instruction_execute_top c8ex_checker u_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .status(status),
	.read_data(read_data), .program_counter(program_counter));

@@ test/chip8_instruction_execute_top_tb.sv @@
// Self-checking testbench for the CHIP-8 execute block: random and directed opcodes
`timescale 1ns / 100ps
module chip8_instruction_execute_top_tb;
	import c8ex_pkg::*;

	typedef struct {
		logic [1:0]  cmd;
		logic [15:0] op;
		logic [11:0] addr;
		logic [7:0]  data;
		logic [15:0] keys;
		logic [3:0]  key;
		logic [7:0]  rnd;
	} c8_txn_t;

	localparam int MEM_BYTES = 4096;
	localparam int STK_DEPTH = 16;
	localparam int LOAD_ADDR = 512;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [1:0] command;
	logic [15:0] opcode;
	logic [11:0] address;
	logic [7:0] data_byte;
	logic [15:0] keys_down;
	logic [3:0] wait_key;
	logic [7:0] random_value;
	logic [11:0] program_counter;
	logic [15:0] index_value;
	logic [7:0] flag_value, delay_value, sound_value, read_data;
	logic [1:0] status;

	chip8_instruction_execute_top dut (.*);

	// shadow CPU state
	logic [7:0]  vreg [16];
	logic [15:0] ireg;
	logic [11:0] pcreg;
	logic [11:0] stack [STK_DEPTH];
	int          sp;
	logic [7:0]  dly, snd;
	logic [7:0]  mem [MEM_BYTES];

	c8_txn_t     pending_txns[$];
	c8_result_t  expected_results[$];
	int          errors = 0;
	int          send_idle_pct = 0, stall_pct = 0;
	bit          hold_off = 0;
	int          quiet_cycles = 0;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic void cond_skip(bit c);
		if (c)
			pcreg = pcreg + 12'd2;
	endfunction

	function automatic c8_result_t cpu_step(c8_txn_t t);
		c8_result_t r;
		logic [3:0] x, y;
		logic [7:0] kk, vx, vy;
		logic [8:0] sum;
		r = '0;
		r.st = ST_OK;
		x = t.op[11:8];
		y = t.op[7:4];
		kk = t.op[7:0];
		if (t.cmd == CMD_WRITE)
			mem[t.addr] = t.data;
		else if (t.cmd == CMD_READ)
			r.rd = mem[t.addr];
		else if (t.cmd == CMD_START)
			pcreg = 12'(LOAD_ADDR);
		else if (t.op == OP_CLS)
			r.st = ST_DISP;
		else if (t.op == OP_RET) begin
			if (sp == 0)
				r.st = ST_UNDER;
			else begin
				sp--;
				pcreg = stack[sp];
			end
		end else begin
			vx = vreg[x];
			vy = vreg[y];
			case (t.op[15:12])
				4'h1: pcreg = t.op[11:0];
				4'h2: begin
					if (sp >= STK_DEPTH)
						r.st = ST_OVER;
					else begin
						stack[sp] = pcreg;
						sp++;
						pcreg = t.op[11:0];
					end
				end
				4'h3: cond_skip(vx == kk);
				4'h4: cond_skip(vx != kk);
				4'h5: cond_skip(vx == vy);
				4'h6: vreg[x] = kk;
				4'h7: vreg[x] = vx + kk;
				4'h8: begin
					case (t.op[3:0])
						4'h0: vreg[x] = vy;
						4'h1: vreg[x] = vx | vy;
						4'h2: vreg[x] = vx & vy;
						4'h3: vreg[x] = vx ^ vy;
						4'h4: begin
							sum = vx + vy;
							vreg[15] = {7'd0, sum[8]};
							vreg[x] = sum[7:0];
						end
						// flag lands first, then operands are reread
						4'h5: begin
							vreg[15] = {7'd0, vx > vy};
							vreg[x] = vreg[x] - vreg[y];
						end
						4'h6: begin
							vreg[15] = {7'd0, vx[0]};
							vreg[x] = vx >> 1;
						end
						4'h7: begin
							vreg[15] = {7'd0, vy > vx};
							vreg[x] = vreg[y] - vreg[x];
						end
						4'hE: begin
							vreg[15] = {7'd0, vx[7]};
							vreg[x] = vx << 1;
						end
						default: ;
					endcase
				end
				4'h9: cond_skip(vx != vy);
				4'hA: ireg = {4'd0, t.op[11:0]};
				4'hB: pcreg = t.op[11:0] + {4'd0, vreg[0]};
				4'hC: vreg[x] = t.rnd & kk;
				4'hD: r.st = ST_DISP;
				4'hE: begin
					if (kk == EX_KEY_DOWN)
						cond_skip(t.keys[vx[3:0]]);
					else if (kk == EX_KEY_UP)
						cond_skip(!t.keys[vx[3:0]]);
				end
				4'hF: begin
					case (kk)
						FX_DELAY_GET: vreg[x] = dly;
						FX_KEY:       vreg[x] = {4'd0, t.key};
						FX_DELAY_SET: dly = vx;
						FX_SOUND_SET: snd = vx;
						FX_ADD_I:     ireg = ireg + {8'd0, vx};
						FX_GLYPH:     ireg = 16'(vx * GLYPH_HEIGHT);
						FX_BCD: begin
							mem[12'(ireg)] = vx / 100;
							mem[12'(ireg + 16'd1)] = (vx / 10) % 10;
							mem[12'(ireg + 16'd2)] = vx % 10;
						end
						FX_STORE:
							for (int i = 0; i <= x; i++)
								mem[12'(ireg + 16'(i))] = vreg[i];
						FX_LOAD:
							for (int i = 0; i <= x; i++)
								vreg[i] = mem[12'(ireg + 16'(i))];
						default: ;
					endcase
				end
				default: ;
			endcase
		end
		r.pc = pcreg;
		r.idx = ireg;
		r.vf = vreg[15];
		r.dly = dly;
		r.snd = snd;
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			command <= '0;
			opcode <= '0;
			address <= '0;
			data_byte <= '0;
			keys_down <= '0;
			wait_key <= '0;
			random_value <= '0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid)
				expected_results.push_back(cpu_step('{command, opcode, address,
					data_byte, keys_down, wait_key, random_value}));
			if (pending_txns.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				c8_txn_t t;
				t = pending_txns.pop_front();
				in_valid <= 1;
				command <= t.cmd;
				opcode <= t.op;
				address <= t.addr;
				data_byte <= t.data;
				keys_down <= t.keys;
				wait_key <= t.key;
				random_value <= t.rnd;
			end else
				in_valid <= 0;
		end
	end

	// receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 0;
		else
			out_stall <= hold_off || ($urandom_range(99) < stall_pct);
	end

	// monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
			if (out_valid && !out_stall) begin
				c8_result_t act, exp_r;
				act = '{program_counter, index_value, flag_value, delay_value,
					sound_value, read_data, status};
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result %h", $time, act);
					errors++;
				end else begin
					exp_r = expected_results.pop_front();
					if (act.pc !== exp_r.pc)
						$display("%0t: pc exp %h got %h", $time, exp_r.pc, act.pc);
					if (act.idx !== exp_r.idx)
						$display("%0t: index exp %h got %h", $time, exp_r.idx, act.idx);
					if (act.vf !== exp_r.vf)
						$display("%0t: vf exp %h got %h", $time, exp_r.vf, act.vf);
					if (act.dly !== exp_r.dly)
						$display("%0t: delay exp %h got %h", $time, exp_r.dly, act.dly);
					if (act.snd !== exp_r.snd)
						$display("%0t: sound exp %h got %h", $time, exp_r.snd, act.snd);
					if (act.rd !== exp_r.rd)
						$display("%0t: read exp %h got %h", $time, exp_r.rd, act.rd);
					if (act.st !== exp_r.st)
						$display("%0t: status exp %h got %h", $time, exp_r.st, act.st);
					if (act !== exp_r)
						errors++;
				end
			end
		end
	end

	function automatic c8_txn_t rand_fields();
		c8_txn_t t;
		t.cmd = CMD_EXEC;
		t.op = 16'($urandom);
		t.addr = 12'($urandom);
		t.data = 8'($urandom);
		t.keys = 16'($urandom);
		t.key = 4'($urandom);
		t.rnd = 8'($urandom_range(254));
		return t;
	endfunction

	task automatic add_op(logic [15:0] op);
		c8_txn_t t;
		t = rand_fields();
		t.op = op;
		pending_txns.push_back(t);
	endtask

	// random item: mostly well-formed opcodes, calls and returns drawn freely so the stack can overflow or underflow
	task automatic add_random();
		c8_txn_t t;
		int pick;
		t = rand_fields();
		pick = $urandom_range(99);
		if (pick < 5)
			t.cmd = CMD_WRITE;
		else if (pick < 12)
			t.cmd = CMD_READ;
		else if (pick < 14)
			t.cmd = CMD_START;
		else if (pick < 20)
			t.op = OP_RET;
		else if (pick < 24)
			t.op = {4'h2, t.op[11:0]};
		else if (pick < 30)
			t.op = {4'hE, t.op[11:8], $urandom_range(1) ? EX_KEY_DOWN : EX_KEY_UP};
		else if (pick < 45) begin
			case ($urandom_range(9))
				0: t.op[7:0] = FX_DELAY_GET;
				1: t.op[7:0] = FX_KEY;
				2: t.op[7:0] = FX_DELAY_SET;
				3: t.op[7:0] = FX_SOUND_SET;
				4: t.op[7:0] = FX_ADD_I;
				5: t.op[7:0] = FX_GLYPH;
				6: t.op[7:0] = FX_BCD;
				7: t.op[7:0] = FX_STORE;
				8: t.op[7:0] = FX_LOAD;
				default: ;
			endcase
			t.op[15:12] = 4'hF;
		end else if (pick < 60)
			t.op[15:12] = 4'h8;
		else if (pick < 68)
			t.op = {4'h6, t.op[11:8], ($urandom_range(3) == 0) ? 8'hFF : t.op[7:0]};
		pending_txns.push_back(t);
	endtask

	task automatic run_phase(int n, int idle, int stall);
		send_idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < n; i++)
			add_random();
		wait (pending_txns.size() == 0 && expected_results.size() == 0);
	endtask

	initial begin
		arst_n = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		// directed: opcode families 0, 1, 2, 3, 6, 7, 8, A, B, C, D and F plus flag-on-VF, stack edges and wraps
		add_op(OP_RET);
		add_op(OP_CLS);
		add_op(16'hD123);
		add_op(16'h0123);
		add_op(16'h6AFF);
		add_op(16'h6F80);
		add_op(16'h8FA4);
		add_op(16'h8AF5);
		add_op(16'h8AF7);
		add_op(16'h8FEE);
		add_op(16'h8A06);
		add_op(16'h8AB9);
		add_op(16'h7AFF);
		add_op(16'hAFFF);
		add_op(16'hF01E);
		add_op(16'hFA33);
		add_op(16'hFF55);
		add_op(16'hFF65);
		add_op(16'hB0FF);
		add_op(16'h1FFE);
		add_op(16'h3000);
		add_op(16'hCFFF);
		for (int i = 0; i <= STK_DEPTH; i++)
			add_op(16'h2FFE);
		for (int i = 0; i <= STK_DEPTH; i++)
			add_op(OP_RET);
		wait (pending_txns.size() == 0 && expected_results.size() == 0);

		// long receiver hold-off while the sender keeps offering
		hold_off = 1;
		for (int i = 0; i < 20; i++)
			add_random();
		repeat (300) @(posedge clk);
		hold_off = 0;
		wait (pending_txns.size() == 0 && expected_results.size() == 0);

		run_phase(350, 0, 0);
		run_phase(300, 79, 0);
		run_phase(300, 0, 79);
		run_phase(300, 24, 24);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		for (int i = 0; i < MEM_BYTES; i++)
			mem[i] = font_byte(7'(i < 80 ? i : 127));
		foreach (vreg[i])
			vreg[i] = '0;
		foreach (stack[i])
			stack[i] = '0;
		ireg = '0;
		pcreg = '0;
		sp = 0;
		dly = '0;
		snd = '0;
	end
endmodule
